@@ rtl/core/dpf_pkg.sv @@
`timescale 1ns / 1ps

package dpf_pkg;

	localparam int HISTORY_DEPTH_DEFAULT = 255;

	localparam int ADDR_W      = 8;
	localparam int SEQ_W       = 8;
	localparam int VERDICT_W   = 2;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_OWN_ADDRESS   = 2'd0,
		REG_RELAY_ADDRESS = 2'd1
	} cfg_reg_t;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_ACCEPTED      = 2'd0,
		VERDICT_NOT_ADDRESSED = 2'd1,
		VERDICT_DUPLICATE     = 2'd2
	} verdict_t;

	typedef struct packed {
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic [SEQ_W-1:0]  seq;
	} entry_t;

endpackage

@@ rtl/core/dpf_cell.sv @@
`timescale 1ns / 1ps

module dpf_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift_en,
	input  dpf_pkg::entry_t d,
	output dpf_pkg::entry_t q
);

	dpf_pkg::entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift_en) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

@@ rtl/core/duplicate_packet_filter.sv @@
`timescale 1ns / 1ps

// Duplicate packet filter. Each header word (source, destination, sequence) gets one
// verdict word: accepted and recorded, not addressed here, or duplicate. The history is a
// row of HISTORY_DEPTH cells forming a shift ring that holds the last HISTORY_DEPTH
// recorded headers (zeros after reset); the oldest falls out when a new one is recorded.
// A lookup rotates the whole ring once past a single comparator at its tail. A recorded
// header goes from idle through the scan, write and done states before its verdict word
// is registered; a duplicate skips the write state, and a header not addressed here goes
// straight from idle to the done state. One header is in work at a time; the next is
// taken once the previous verdict has gone to the output register. Configuration writes
// are taken in any cycle and should be made while idle.

module duplicate_packet_filter #(
	parameter int HISTORY_DEPTH = dpf_pkg::HISTORY_DEPTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dpf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [dpf_pkg::CFG_DATA_W-1:0]  cfg_data,

	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [dpf_pkg::ADDR_W-1:0]      src_address,
	input  logic [dpf_pkg::ADDR_W-1:0]      dst_address,
	input  logic [dpf_pkg::SEQ_W-1:0]       seq_number,

	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [dpf_pkg::VERDICT_W-1:0]   verdict
);

	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(HISTORY_DEPTH - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WRITE,
		S_DONE
	} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              scan_cnt_q;
	logic                          hit_q;
	dpf_pkg::entry_t               key_q;
	dpf_pkg::verdict_t             verdict_pend_q;
	dpf_pkg::verdict_t             verdict_q;
	logic                          out_valid_q;
	logic [dpf_pkg::ADDR_W-1:0]    own_address_q;
	logic [dpf_pkg::ADDR_W-1:0]    relay_address_q;

	dpf_pkg::entry_t               chain [HISTORY_DEPTH+1];
	dpf_pkg::entry_t               tail;
	logic                          shift_en;
	logic                          match;
	logic                          addressed;
	logic                          in_fire;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign addressed = (dst_address == own_address_q) || (relay_address_q != '0);

	assign tail     = chain[HISTORY_DEPTH];
	assign match    = (tail == key_q);
	assign shift_en = (state_q == S_SCAN) || (state_q == S_WRITE);
	assign chain[0] = (state_q == S_SCAN) ? tail : key_q;

	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
		dpf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (shift_en),
			.d        (chain[i]),
			.q        (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q   <= '0;
			relay_address_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				dpf_pkg::REG_OWN_ADDRESS:   own_address_q   <= cfg_data;
				dpf_pkg::REG_RELAY_ADDRESS: relay_address_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			scan_cnt_q     <= '0;
			hit_q          <= 1'b0;
			key_q          <= '0;
			verdict_pend_q <= dpf_pkg::VERDICT_ACCEPTED;
			verdict_q      <= dpf_pkg::VERDICT_ACCEPTED;
			out_valid_q    <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						key_q      <= '{src: src_address, dst: dst_address, seq: seq_number};
						scan_cnt_q <= '0;
						hit_q      <= 1'b0;
						if (addressed) begin
							state_q <= S_SCAN;
						end else begin
							verdict_pend_q <= dpf_pkg::VERDICT_NOT_ADDRESSED;
							state_q        <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (scan_cnt_q == LAST_STEP) begin
						if (hit_q || match) begin
							verdict_pend_q <= dpf_pkg::VERDICT_DUPLICATE;
							state_q        <= S_DONE;
						end else begin
							state_q <= S_WRITE;
						end
					end else begin
						hit_q      <= hit_q || match;
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end
				end
				S_WRITE: begin
					verdict_pend_q <= dpf_pkg::VERDICT_ACCEPTED;
					state_q        <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						verdict_q   <= verdict_pend_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

	a_not_addressed: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !addressed) |=>
			(state_q == S_DONE && verdict_pend_q == dpf_pkg::VERDICT_NOT_ADDRESSED))
		else $error("header not addressed here did not get its verdict");

	a_write_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |-> !hit_q)
		else $error("history written after a match");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (scan_cnt_q <= LAST_STEP))
		else $error("scan ran past the ring length");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !out_ready) |=>
			(state_q == S_DONE && $stable(verdict_q)))
		else $error("pending verdict overwrote an untaken word");

endmodule

@@ dv/dpf_checker.sv @@
`timescale 1ns / 1ps

module dpf_checker #(
	parameter int HISTORY_DEPTH = dpf_pkg::HISTORY_DEPTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [dpf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [dpf_pkg::CFG_DATA_W-1:0]  cfg_data,

	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [dpf_pkg::ADDR_W-1:0]      src_address,
	input  logic [dpf_pkg::ADDR_W-1:0]      dst_address,
	input  logic [dpf_pkg::SEQ_W-1:0]       seq_number,

	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [dpf_pkg::VERDICT_W-1:0]   verdict,

	output int                              fail_count,
	output int                              outstanding,
	output int                              accepted_count,
	output int                              duplicate_count,
	output int                              unaddressed_count
);

	import dpf_pkg::*;

	localparam int PRINT_CAP = 40;

	entry_t                 seen_headers [HISTORY_DEPTH];
	int unsigned            slot_ptr;
	logic [ADDR_W-1:0]      node_addr;
	logic [ADDR_W-1:0]      relay_addr;
	verdict_t               pending_verdicts [$];
	int                     mismatches;
	int                     n_accepted;
	int                     n_duplicate;
	int                     n_unaddressed;

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_CAP) begin
			$display("dpf mismatch at %0t ns: %s", $time, what);
		end
		mismatches++;
	endtask

	function automatic verdict_t screen_header(input entry_t hdr);
		if (hdr.dst != node_addr && relay_addr == '0) begin
			return VERDICT_NOT_ADDRESSED;
		end
		foreach (seen_headers[i]) begin
			if (seen_headers[i] == hdr) begin
				return VERDICT_DUPLICATE;
			end
		end
		seen_headers[slot_ptr] = hdr;
		slot_ptr = (slot_ptr + 1) % HISTORY_DEPTH;
		return VERDICT_ACCEPTED;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t want;
		entry_t   hdr;
		if (!arst_n) begin
			foreach (seen_headers[i]) begin
				seen_headers[i] = '0;
			end
			slot_ptr = 0;
			node_addr = '0;
			relay_addr = '0;
			pending_verdicts.delete();
			mismatches = 0;
			n_accepted = 0;
			n_duplicate = 0;
			n_unaddressed = 0;
			fail_count <= 0;
			outstanding <= 0;
			accepted_count <= 0;
			duplicate_count <= 0;
			unaddressed_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_OWN_ADDRESS: node_addr = cfg_data;
					REG_RELAY_ADDRESS: relay_addr = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				hdr.src = src_address;
				hdr.dst = dst_address;
				hdr.seq = seq_number;
				pending_verdicts.push_back(screen_header(hdr));
			end
			if (out_valid && out_ready) begin
				if (pending_verdicts.size() == 0) begin
					report_mismatch($sformatf("verdict word %0d with no header waiting", verdict));
				end else begin
					want = pending_verdicts.pop_front();
					if (verdict !== want) begin
						report_mismatch($sformatf("verdict %0d, predicted %0d (%s)",
							verdict, want, want.name()));
					end
					case (want)
						VERDICT_ACCEPTED: n_accepted++;
						VERDICT_DUPLICATE: n_duplicate++;
						default: n_unaddressed++;
					endcase
				end
			end
			fail_count <= mismatches;
			outstanding <= pending_verdicts.size();
			accepted_count <= n_accepted;
			duplicate_count <= n_duplicate;
			unaddressed_count <= n_unaddressed;
		end
	end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	import dpf_pkg::*;

	localparam int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 272;
	localparam int LOG_DEPTH = 400;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [ADDR_W-1:0]      src_address = '0;
	logic [ADDR_W-1:0]      dst_address = '0;
	logic [SEQ_W-1:0]       seq_number = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [VERDICT_W-1:0]   verdict;

	int fail_count;
	int outstanding;
	int accepted_count;
	int duplicate_count;
	int unaddressed_count;

	int          cycle_count = 0;
	int          idle_pct = 0;
	int          stall_left = 0;
	int          headers_sent = 0;
	int          settings_count = 0;
	bit          spare_flip = 1'b0;
	logic [7:0]  cur_own = '0;
	entry_t      sent_log [$];

	duplicate_packet_filter #(.HISTORY_DEPTH(HISTORY_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.src_address(src_address),
		.dst_address(dst_address),
		.seq_number(seq_number),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.verdict(verdict)
	);

	dpf_checker #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.src_address(src_address),
		.dst_address(dst_address),
		.seq_number(seq_number),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.verdict(verdict),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.accepted_count(accepted_count),
		.duplicate_count(duplicate_count),
		.unaddressed_count(unaddressed_count)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// stall the verdict side in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(17);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic push_header(input entry_t hdr);
		int gap;
		gap = 0;
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 18);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		src_address <= hdr.src;
		dst_address <= hdr.dst;
		seq_number <= hdr.seq;
		do @(posedge clk); while (!in_ready);
		sent_log.push_back(hdr);
		if (sent_log.size() > LOG_DEPTH) begin
			void'(sent_log.pop_front());
		end
		headers_sent++;
	endtask

	// drop valid and hold until every verdict word is back
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic configure(input logic [7:0] own, input logic [7:0] relay);
		logic [CFG_INDEX_W-1:0] idx [3];
		logic [CFG_DATA_W-1:0]  val [3];
		idx[0] = REG_OWN_ADDRESS;
		val[0] = own;
		idx[1] = spare_flip ? REG_SPARE_3 : REG_SPARE_2;
		val[1] = 8'($urandom());
		idx[2] = REG_RELAY_ADDRESS;
		val[2] = relay;
		spare_flip = !spare_flip;
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		cur_own = own;
		settings_count++;
	endtask

	function automatic entry_t pick_header();
		int     roll;
		int     back;
		entry_t hdr;
		roll = $urandom_range(99);
		if (roll < 32 && sent_log.size() > 0) begin
			back = ($urandom_range(3) == 0) ? $urandom_range(230, 290) : $urandom_range(24);
			if (back >= sent_log.size()) begin
				back = sent_log.size() - 1;
			end
			hdr = sent_log[sent_log.size() - 1 - back];
		end else if (roll < 36) begin
			hdr = '0;
		end else begin
			hdr.src = $urandom_range(1) ? 8'($urandom_range(7)) : 8'($urandom());
			hdr.dst = ($urandom_range(99) < 70) ? cur_own : 8'($urandom());
			hdr.seq = 8'($urandom());
		end
		return hdr;
	endfunction

	initial begin
		logic [7:0] own_sel [PHASES];
		logic [7:0] relay_sel [PHASES];
		int         pct_sel [PHASES];

		own_sel = '{8'h5A, 8'($urandom()), 8'h00, 8'hFF, 8'($urandom()), 8'($urandom())};
		relay_sel = '{8'h00, 8'hFF, 8'h00, 8'h01, 8'($urandom_range(1, 255)), 8'h00};
		pct_sel = '{25, 0, 40, 15, 30, 0};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: node address zero, relay off
		push_header('{8'h00, 8'h00, 8'h00});
		push_header('{8'h00, 8'h07, 8'h00});
		push_header('{8'h01, 8'h00, 8'h01});
		push_header('{8'h01, 8'h00, 8'h01});
		push_header('{8'hFF, 8'h00, 8'hFF});
		push_header('{8'hFF, 8'hFF, 8'hFF});
		push_header('{8'h00, 8'h00, 8'hFF});
		push_header('{8'hFF, 8'h00, 8'h00});
		settle();

		configure(8'hFF, 8'h00);
		push_header('{8'hFF, 8'hFF, 8'hFF});
		push_header('{8'h00, 8'h00, 8'h00});
		push_header('{8'h01, 8'h00, 8'h01});
		push_header('{8'hFF, 8'hFF, 8'hFF});
		push_header('{8'hAA, 8'hFF, 8'h55});
		settle();

		configure(8'h81, 8'h01);
		push_header('{8'h01, 8'h00, 8'h01});
		push_header('{8'h00, 8'h00, 8'h00});
		push_header('{8'h55, 8'hAA, 8'h55});
		push_header('{8'h55, 8'hAA, 8'h55});
		push_header('{8'h00, 8'hFE, 8'h80});
		settle();

		for (int p = 0; p < PHASES; p++) begin
			configure(own_sel[p], relay_sel[p]);
			idle_pct = pct_sel[p];
			repeat (ITEMS_PER_PHASE) push_header(pick_header());
			settle();
		end

		repeat (HISTORY_DEPTH + 8) @(posedge clk);

		$display("run: %0d headers under %0d register settings, spare indexes written too",
			headers_sent, settings_count + 1);
		$display("run: %0d accepted, %0d duplicate, %0d not addressed",
			accepted_count, duplicate_count, unaddressed_count);
		if (fail_count == 0 && outstanding == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
